[hw/rtl/e2q_pkg.sv]
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int QUAT_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 14;
  localparam int TABLE_LEN         = 22;
  localparam int FRAC              = 30;
  localparam int POS_BITS          = 32;

  // internal datapath width: q30 values with headroom
  localparam int DW = 34;

  localparam logic signed [DW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [DW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [DW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // arctangent table, q30
  function automatic logic signed [DW-1:0] atan_q30(input int idx);
    logic signed [DW-1:0] r;
    begin
      case (idx)
        0:  r = 34'sd843314857;
        1:  r = 34'sd497837829;
        2:  r = 34'sd263043837;
        3:  r = 34'sd133525159;
        4:  r = 34'sd67021687;
        5:  r = 34'sd33543516;
        6:  r = 34'sd16775851;
        7:  r = 34'sd8388437;
        8:  r = 34'sd4194283;
        9:  r = 34'sd2097149;
        10: r = 34'sd1048576;
        11: r = 34'sd524288;
        12: r = 34'sd262144;
        13: r = 34'sd131072;
        14: r = 34'sd65536;
        15: r = 34'sd32768;
        16: r = 34'sd16384;
        17: r = 34'sd8192;
        18: r = 34'sd4096;
        19: r = 34'sd2048;
        20: r = 34'sd1024;
        21: r = 34'sd512;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // one angle's cordic vector as handed between cells
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 flip;
  } e2q_vec_t;

  // q30 product rounded back to q30
  function automatic logic signed [DW-1:0] mul_q30(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (FRAC - 1));
      return DW'(p >>> FRAC);
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/e2q_cell.sv]
`default_nettype none
module e2q_cell import e2q_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic     clk,
  input  wire e2q_vec_t a_in,
  input  wire e2q_vec_t b_in,
  input  wire e2q_vec_t c_in,
  output e2q_vec_t      a_out,
  output e2q_vec_t      b_out,
  output e2q_vec_t      c_out
);

  localparam logic signed [DW-1:0] ATAN = atan_q30(IDX);

  // one micro-rotation step
  function automatic e2q_vec_t rot(input e2q_vec_t v);
    e2q_vec_t r;
    begin
      r = v;
      if (!v.z[DW-1]) begin
        r.x = v.x - (v.y >>> IDX);
        r.y = v.y + (v.x >>> IDX);
        r.z = v.z - ATAN;
      end else begin
        r.x = v.x + (v.y >>> IDX);
        r.y = v.y - (v.x >>> IDX);
        r.z = v.z + ATAN;
      end
      return r;
    end
  endfunction

  // payload stage, no reset needed
  always_ff @(posedge clk) begin
    a_out <= rot(a_in);
    b_out <= rot(b_in);
    c_out <= rot(c_in);
  end

endmodule
`default_nettype wire

[hw/rtl/e2q_combine.sv]
`default_nettype none
module e2q_combine import e2q_pkg::*; #(
  parameter int QUAT_BITS = QUAT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic signed [DW-1:0]        cr,
  input  wire logic signed [DW-1:0]        sr,
  input  wire logic signed [DW-1:0]        cp,
  input  wire logic signed [DW-1:0]        sp,
  input  wire logic signed [DW-1:0]        cy,
  input  wire logic signed [DW-1:0]        sy,
  output logic signed [QUAT_BITS-1:0]      qw,
  output logic signed [QUAT_BITS-1:0]      qx,
  output logic signed [QUAT_BITS-1:0]      qy,
  output logic signed [QUAT_BITS-1:0]      qz
);

  localparam int SH = FRAC - (QUAT_BITS - 2);
  localparam logic signed [DW-1:0] ONE  = DW'(64'sd1 <<< (QUAT_BITS - 2));
  localparam logic signed [DW-1:0] RND  = DW'(64'sd1 <<< (SH - 1));

  logic signed [DW-1:0] crcp, srsp, crsp, srcp, cy1, sy1;
  logic signed [DW-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
  logic signed [DW-1:0] s0, s1, s2, s3;

  function automatic logic signed [QUAT_BITS-1:0] to_quat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    begin
      r = (v + RND) >>> SH;
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      return r[QUAT_BITS-1:0];
    end
  endfunction

  // first products
  always_ff @(posedge clk) begin
    crcp <= mul_q30(cr, cp);
    srsp <= mul_q30(sr, sp);
    crsp <= mul_q30(cr, sp);
    srcp <= mul_q30(sr, cp);
    cy1  <= cy;
    sy1  <= sy;
  end

  // second products
  always_ff @(posedge clk) begin
    p0 <= mul_q30(crcp, cy1);
    p1 <= mul_q30(srsp, sy1);
    p2 <= mul_q30(srcp, cy1);
    p3 <= mul_q30(crsp, sy1);
    p4 <= mul_q30(crsp, cy1);
    p5 <= mul_q30(srcp, sy1);
    p6 <= mul_q30(crcp, sy1);
    p7 <= mul_q30(srsp, cy1);
  end

  // sums
  always_ff @(posedge clk) begin
    s0 <= p0 + p1;
    s1 <= p2 - p3;
    s2 <= p4 + p5;
    s3 <= p6 - p7;
  end

  // round and saturate
  always_ff @(posedge clk) begin
    qw <= to_quat(s0);
    qx <= to_quat(s1);
    qy <= to_quat(s2);
    qz <= to_quat(s3);
  end

endmodule
`default_nettype wire

[hw/rtl/euler_to_quaternion_pose_top.sv]
`default_nettype none
// start to strobe: prep register, cordic cell row, sign restore, then the combine stages
// throughput: one beat per cycle; busy is tied low, the cordic cell row and
// multiplier stages are fully pipelined
// results are presented for one cycle on strobe; the receiver cannot stall
// reset: rst (synchronous) clears the valid pipeline only
module euler_to_quaternion_pose_top import e2q_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int QUAT_BITS     = QUAT_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [POS_BITS-1:0]   pos_x,
  input  wire logic signed [POS_BITS-1:0]   pos_y,
  input  wire logic signed [POS_BITS-1:0]   pos_z,
  input  wire logic signed [ANGLE_BITS-1:0] roll_angle,
  input  wire logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  wire logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic                              strobe,
  output logic signed [POS_BITS-1:0]        out_x,
  output logic signed [POS_BITS-1:0]        out_y,
  output logic signed [POS_BITS-1:0]        out_z,
  output logic signed [QUAT_BITS-1:0]       quat_w,
  output logic signed [QUAT_BITS-1:0]       quat_x,
  output logic signed [QUAT_BITS-1:0]       quat_y,
  output logic signed [QUAT_BITS-1:0]       quat_z
);

  localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int LAT = NST + 6;
  localparam int SCL = FRAC - 1 - (ANGLE_BITS - 4);

  e2q_vec_t va [NST+1];
  e2q_vec_t vb [NST+1];
  e2q_vec_t vc [NST+1];
  logic                  vld [LAT];
  logic [3*POS_BITS-1:0] pos [LAT];

  assign busy = 1'b0;

  // half angle with range reduction
  function automatic e2q_vec_t prep(input logic signed [ANGLE_BITS-1:0] a);
    e2q_vec_t v;
    logic signed [DW-1:0] th;
    begin
      th = DW'(a) <<< SCL;
      v.flip = 1'b0;
      if (th > HALF_PI_Q30) begin
        th = th - PI_Q30;
        v.flip = 1'b1;
      end else if (th < -HALF_PI_Q30) begin
        th = th + PI_Q30;
        v.flip = 1'b1;
      end
      v.x = GAIN_Q30;
      v.y = '0;
      v.z = th;
      return v;
    end
  endfunction

  always_ff @(posedge clk) begin
    va[0] <= prep(roll_angle);
    vb[0] <= prep(pitch_angle);
    vc[0] <= prep(yaw_angle);
  end

  // cordic cell row
  for (genvar i = 0; i < NST; i++) begin : g_cell
    e2q_cell #(.IDX(i)) u_cell (
      .clk(clk),
      .a_in(va[i]), .b_in(vb[i]), .c_in(vc[i]),
      .a_out(va[i+1]), .b_out(vb[i+1]), .c_out(vc[i+1])
    );
  end

  // sign restore after the row
  logic signed [DW-1:0] cr, sr, cp, sp, cy, sy;
  always_ff @(posedge clk) begin
    cr <= va[NST].flip ? -va[NST].x : va[NST].x;
    sr <= va[NST].flip ? -va[NST].y : va[NST].y;
    cp <= vb[NST].flip ? -vb[NST].x : vb[NST].x;
    sp <= vb[NST].flip ? -vb[NST].y : vb[NST].y;
    cy <= vc[NST].flip ? -vc[NST].x : vc[NST].x;
    sy <= vc[NST].flip ? -vc[NST].y : vc[NST].y;
  end

  e2q_combine #(.QUAT_BITS(QUAT_BITS)) u_comb (
    .clk(clk), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z)
  );

  // valid and position delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    pos[0] <= {pos_x, pos_y, pos_z};
    for (int k = 1; k < LAT; k++) pos[k] <= pos[k-1];
  end

  assign strobe = vld[LAT-1];
  assign out_x  = pos[LAT-1][3*POS_BITS-1:2*POS_BITS];
  assign out_y  = pos[LAT-1][2*POS_BITS-1:POS_BITS];
  assign out_z  = pos[LAT-1][POS_BITS-1:0];

endmodule
`default_nettype wire
